// ===== hw/rtl/qtes_pkg.sv =====
// Shared types and constants for the quadtree tile edge sharing block.
package qtes_pkg;

  localparam int LOD_W = 5;
  localparam int IDX_W = 23;
  localparam int RES_W = 11;

  localparam int MAX_RESOLUTION = 1024;
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(32);

  // Largest level gap is 2**LOD_W - 1, so an offset inside a tile spans that many bits.
  localparam int OFF_W = (2 ** LOD_W) - 1;
  // Visited key scaled to the updated level, plus one bit for the far edge.
  localparam int KEY_W = IDX_W + OFF_W + 1;

  typedef enum logic [2:0] {
    REL_UNRELATED = 3'd0,
    REL_SAME      = 3'd1,
    REL_EDGES     = 3'd2,
    REL_CORNER    = 3'd3,
    REL_ORDER_ERR = 3'd4
  } relation_t;

  typedef enum logic [1:0] {
    EDGE_BOTTOM = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_t;

  typedef enum logic [1:0] {
    CORNER_R0_C0 = 2'd0,
    CORNER_RL_C0 = 2'd1,
    CORNER_R0_CL = 2'd2,
    CORNER_RL_CL = 2'd3
  } corner_t;

  typedef struct packed {
    logic [LOD_W-1:0] visited_lod;
    logic [IDX_W-1:0] visited_col;
    logic [IDX_W-1:0] visited_row;
    logic [LOD_W-1:0] updated_lod;
    logic [IDX_W-1:0] updated_col;
    logic [IDX_W-1:0] updated_row;
  } tile_pair_t;

  typedef struct packed {
    relation_t        relation;
    logic [1:0]       edge_count;
    edge_t            visited_edge_a;
    edge_t            updated_edge_a;
    logic [RES_W-1:0] start_a;
    edge_t            visited_edge_b;
    edge_t            updated_edge_b;
    logic [RES_W-1:0] start_b;
    logic [LOD_W-1:0] level_gap;
    logic [RES_W-1:0] copy_count;
    corner_t          corner_code;
  } adj_result_t;

endpackage

// ===== hw/rtl/qtes_classify.sv =====
// Combinational classifier: relation, shared edges and vertex ranges for one tile pair.
module qtes_classify (
  input  qtes_pkg::tile_pair_t        item,
  input  logic [qtes_pkg::RES_W-1:0]  resolution,
  output qtes_pkg::adj_result_t       result
);
  import qtes_pkg::*;

  logic                     order_ok;
  logic [LOD_W-1:0]         gap;
  logic [KEY_W-1:0]         mult, mask;
  logic [KEY_W-1:0]         tx, ty, txe, tye;
  logic [KEY_W-1:0]         ux, uy, ux1, uy1;
  logic                     same, contains, xadj, yadj, xin, yin, nb, below;
  logic [IDX_W-1:0]         offx;
  logic [OFF_W-1:0]         offy;
  logic [IDX_W+RES_W-1:0]   prodx;
  logic [OFF_W+RES_W-1:0]   prody;
  logic [RES_W-1:0]         startx, starty, res_shift;
  logic [1:0]               n;
  edge_t                    ve_a, ue_a, ve_b, ue_b, e_y;

  assign order_ok = item.visited_lod <= item.updated_lod;
  assign gap      = item.updated_lod - item.visited_lod;

  assign mult = KEY_W'(1) << gap;
  assign mask = mult - KEY_W'(1);
  assign tx   = KEY_W'(item.visited_col) << gap;
  assign ty   = KEY_W'(item.visited_row) << gap;
  assign txe  = tx + mult;
  assign tye  = ty + mult;
  assign ux   = KEY_W'(item.updated_col);
  assign uy   = KEY_W'(item.updated_row);
  assign ux1  = ux + KEY_W'(1);
  assign uy1  = uy + KEY_W'(1);

  assign same     = (item.visited_lod == item.updated_lod) &&
                    (item.visited_col == item.updated_col) &&
                    (item.visited_row == item.updated_row);
  assign contains = (ux >= tx) && (ux < txe) && (uy >= ty) && (uy < tye);
  assign xadj     = (tx == ux1) || (txe == ux);
  assign yadj     = (ty == uy1) || (tye == uy);
  assign xin      = (ux >= tx) && (ux1 <= txe);
  assign yin      = (uy >= ty) && (uy1 <= tye);
  assign nb       = xadj ? yin : (yadj ? xin : 1'b0);
  assign below    = (uy == tye);

  // tx, ty have zero low bits; offx is the low bits of ux, offy those of uy inverted.
  assign offx  = item.updated_col & mask[IDX_W-1:0];
  assign offy  = OFF_W'(~uy & mask);
  assign prodx = {{RES_W{1'b0}}, offx} * {{IDX_W{1'b0}}, resolution};
  assign prody = {{RES_W{1'b0}}, offy} * {{OFF_W{1'b0}}, resolution};
  assign startx = RES_W'(prodx >> gap);
  assign starty = RES_W'(prody >> gap);

  assign res_shift = resolution >> gap;

  always_comb begin
    result = '0;
    n      = 2'd0;
    ve_a   = EDGE_BOTTOM;
    ue_a   = EDGE_BOTTOM;
    ve_b   = EDGE_BOTTOM;
    ue_b   = EDGE_BOTTOM;
    e_y    = (ty == uy) ? EDGE_TOP : EDGE_BOTTOM;
    if (!order_ok) begin
      result.relation = REL_ORDER_ERR;
    end else begin
      result.level_gap  = gap;
      result.copy_count = res_shift + RES_W'(1);
      if (same) begin
        result.relation = REL_SAME;
      end else if (contains) begin
        result.relation = REL_EDGES;
        if (tx == ux) begin
          ve_a = EDGE_LEFT;
          ue_a = EDGE_LEFT;
          n    = 2'd1;
        end else if (txe == ux1) begin
          ve_a = EDGE_RIGHT;
          ue_a = EDGE_RIGHT;
          n    = 2'd1;
        end
        if ((ty == uy) || (tye == uy1)) begin
          if (n == 2'd0) begin
            ve_a = e_y;
            ue_a = e_y;
          end else begin
            ve_b = e_y;
            ue_b = e_y;
          end
          n = n + 2'd1;
        end
      end else if (nb) begin
        result.relation = REL_EDGES;
        n = 2'd1;
        if (tx == ux1) begin
          ve_a = EDGE_LEFT;
          ue_a = EDGE_RIGHT;
        end else if (txe == ux) begin
          ve_a = EDGE_RIGHT;
          ue_a = EDGE_LEFT;
        end else if (ty == uy1) begin
          ve_a = EDGE_TOP;
          ue_a = EDGE_BOTTOM;
        end else begin
          ve_a = EDGE_BOTTOM;
          ue_a = EDGE_TOP;
        end
      end else if (xadj && yadj) begin
        result.relation = REL_CORNER;
        if (ux < tx) begin
          result.corner_code = below ? CORNER_R0_C0 : CORNER_RL_C0;
        end else begin
          result.corner_code = below ? CORNER_R0_CL : CORNER_RL_CL;
        end
      end else begin
        result.relation = REL_UNRELATED;
      end
    end
    result.edge_count = n;
    if (n != 2'd0) begin
      result.visited_edge_a = ve_a;
      result.updated_edge_a = ue_a;
      result.start_a = ((ve_a == EDGE_BOTTOM) || (ve_a == EDGE_TOP)) ? startx : starty;
    end
    if (n == 2'd2) begin
      result.visited_edge_b = ve_b;
      result.updated_edge_b = ue_b;
      result.start_b = ((ve_b == EDGE_BOTTOM) || (ve_b == EDGE_TOP)) ? startx : starty;
    end
  end

endmodule

// ===== hw/rtl/quadtree_tile_edge_sharing_top.sv =====
// Top level: input register, classifier and result register with valid/ready on both sides.
// Takes one tile pair per cycle and returns one result item per pair, passing each pair
// through the input register and then the result register; the input register and the
// result register each stall only when the stage after them is full, so the block streams
// at one item per clock. Those two registers sit around the combinational classifier (a
// 55-bit key shift and compare plus a 23x11 and a 31x11 multiply for the edge offsets).
// grid_resolution is written through cfg_wr_en/cfg_wr_data; zero is stored as 1 and values
// above the maximum resolution are clamped to it. Reset value is 32.
module quadtree_tile_edge_sharing_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [qtes_pkg::RES_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  qtes_pkg::tile_pair_t        in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output qtes_pkg::adj_result_t       out_item
);
  import qtes_pkg::*;

  logic [RES_W-1:0] grid_resolution, grid_resolution_next;
  logic             s1_valid, s1_ready;
  tile_pair_t       s1_item;
  adj_result_t      s1_result;

  always_comb begin
    grid_resolution_next = grid_resolution;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        grid_resolution_next = RES_W'(1);
      end else if (32'(cfg_wr_data) > MAX_RESOLUTION) begin
        grid_resolution_next = RES_W'(MAX_RESOLUTION);
      end else begin
        grid_resolution_next = cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_resolution <= RES_RESET;
    end else begin
      grid_resolution <= grid_resolution_next;
    end
  end

  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  qtes_classify u_classify (
    .item       (s1_item),
    .resolution (grid_resolution),
    .result     (s1_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      out_item <= s1_result;
    end
  end

endmodule

// ===== hw/rtl/qtes_checker.sv =====
// Port-level checks for the quadtree tile edge sharing block, bound to the top level.
module qtes_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input qtes_pkg::adj_result_t out_item
);
  import qtes_pkg::*;

  // Both pipeline stages are empty after reset.
  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result item changed");

  a_order_err_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.relation == REL_ORDER_ERR) |->
      (out_item.edge_count == 2'd0) && (out_item.level_gap == '0) &&
      (out_item.copy_count == '0))
    else $error("order error item carries data");

  a_edges_only_on_share: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.edge_count != 2'd0) |->
      (out_item.relation == REL_EDGES) && (out_item.corner_code == CORNER_R0_C0))
    else $error("edges reported outside edge relation");

  a_same_tile: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.relation == REL_SAME) |->
      (out_item.level_gap == '0) && (out_item.edge_count == 2'd0) &&
      (out_item.copy_count != '0))
    else $error("same tile item malformed");

endmodule

bind quadtree_tile_edge_sharing_top qtes_checker u_qtes_checker (.*);
